// ===== design/jsv_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON syntax validator package
// Shared literal selector codes, the class bundle passed from the byte
// classifier to the parser, and the configuration register indexes.
// ----------------------------------------------------------------------------
package jsv_pkg;

   localparam int ByteWidth = 8;

   // Width of the value counter and of the reported value count.
   localparam int CountBits = 17;

   // Register indexes on the configuration port.
   localparam logic [0:0] RegMaxDepth  = 1'b0;
   localparam logic [0:0] RegMaxValues = 1'b1;

   // Literal selector codes.
   typedef enum logic [1:0] {
      LIT_NULL  = 2'd0,
      LIT_TRUE  = 2'd1,
      LIT_FALSE = 2'd2
   } lit_sel_type;

   // Class flags computed once per byte in the front end.
   typedef struct packed {
      logic ws;
      logic digit;
      logic digit19;
      logic hex;
      logic exp_e;
      logic ctrl;
      logic term;
      logic esc_ok;
      logic last;
      logic [ByteWidth-1:0] data;
   } byte_class_type;

   // Expected character of a literal at a given position (1..3; 1..4 for false).
   function automatic logic [ByteWidth-1:0] lit_char(input lit_sel_type sel,
                                                     input logic [2:0] pos);
      logic [ByteWidth-1:0] c;
      c = 8'h00;
      case (sel)
         LIT_NULL:  case (pos)
                       3'd1: c = "u";
                       3'd2: c = "l";
                       3'd3: c = "l";
                       default: c = 8'h00;
                    endcase
         LIT_TRUE:  case (pos)
                       3'd1: c = "r";
                       3'd2: c = "u";
                       3'd3: c = "e";
                       default: c = 8'h00;
                    endcase
         default:   case (pos)
                       3'd1: c = "a";
                       3'd2: c = "l";
                       3'd3: c = "s";
                       3'd4: c = "e";
                       default: c = 8'h00;
                    endcase
      endcase
      return c;
   endfunction

   function automatic logic [2:0] lit_len(input lit_sel_type sel);
      return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
   endfunction

endpackage

// ===== design/jsv_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for input bytes and for document results.
// ----------------------------------------------------------------------------
interface jsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       is_last;
   modport source (output valid, output byte_in, output is_last, input ready);
   modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface jsv_rsp_if
   import jsv_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 well_formed;
   logic [CountBits-1:0] value_count;
   modport source (output valid, output well_formed, output value_count, input ready);
   modport sink   (input valid, input well_formed, input value_count, output ready);
endinterface

// ===== design/json_syntax_validator.sv =====
// ----------------------------------------------------------------------------
// JSON syntax validator, top level
// Streams a JSON document one byte per beat and reports on the final byte.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | byte_in[7:0], is_last
//  rsp     | out       | well_formed, value_count[16:0]
//  csr     | in (APB)  | max_depth at 0x0, max_values at 0x4
//
// The parser handles each byte in a single mode update, so a beat can be
// taken every cycle while no result waits; that mode update sets the rate.
// A result is registered in the cycle after the final byte reaches the parser. Reset is
// synchronous and clears all control state. While a result waits, the parser
// holds, and a two-entry queue behind the input absorbs two more beats.
module json_syntax_validator
   import jsv_pkg::*;
#(
   parameter int STACK_DEPTH = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   jsv_req_if.sink               req,
   jsv_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [5:0]     max_depth_ff;
   logic [16:0]    max_values_ff;
   logic           q_valid, q_pop;
   byte_class_type q_data;

   // Configuration registers: written in the access phase of an APB write.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff  <= 6'd32;
         max_values_ff <= 17'h10000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == RegMaxDepth) max_depth_ff <= csr_pwdata[5:0];
         else max_values_ff <= csr_pwdata[16:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == RegMaxDepth) ? {26'd0, max_depth_ff}
                                                     : {15'd0, max_values_ff};

   jsv_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready),
      .in_byte  (req.byte_in), .in_last (req.is_last),
      .q_valid, .q_pop, .q_data
   );

   jsv_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .max_depth (max_depth_ff), .max_values (max_values_ff),
      .out_valid (rsp.valid), .out_ready (rsp.ready),
      .out_well_formed (rsp.well_formed), .out_count (rsp.value_count)
   );

endmodule

// ===== design/jsv_front.sv =====
// ----------------------------------------------------------------------------
// JSV front end
// Accepts bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module jsv_front
   import jsv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output logic           q_valid,
   input  logic           q_pop,
   output byte_class_type q_data
);

   byte_class_type cls;
   byte_class_type mem_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     cnt_ff;
   logic           push;

   always_comb begin
      cls.data    = in_byte;
      cls.last    = in_last;
      cls.ws      = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0D
                    || in_byte == 8'h0A;
      cls.digit   = in_byte >= "0" && in_byte <= "9";
      cls.digit19 = in_byte >= "1" && in_byte <= "9";
      cls.hex     = cls.digit || (in_byte >= "a" && in_byte <= "f")
                    || (in_byte >= "A" && in_byte <= "F");
      cls.exp_e   = in_byte == "e" || in_byte == "E";
      cls.ctrl    = in_byte < 8'h20;
      cls.term    = cls.ws || in_byte == "," || in_byte == "}" || in_byte == "]";
      cls.esc_ok  = in_byte == "\"" || in_byte == "\\" || in_byte == "/"
                    || in_byte == "b" || in_byte == "f" || in_byte == "n"
                    || in_byte == "r" || in_byte == "t";
   end

   assign in_ready = cnt_ff != 2'd2;
   assign push     = in_valid && in_ready;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

// ===== design/jsv_back.sv =====
// ----------------------------------------------------------------------------
// JSV back end
// Parser state machine, container stack and value counter; one byte a cycle while no result waits.
// ----------------------------------------------------------------------------
module jsv_back
   import jsv_pkg::*;
#(
   parameter int STACK_DEPTH = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  byte_class_type       q_data,
   input  logic [5:0]           max_depth,
   input  logic [16:0]          max_values,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_well_formed,
   output logic [CountBits-1:0] out_count
);

   localparam int LW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(STACK_DEPTH);

   typedef enum logic [4:0] {
      MD_VALUE, MD_FIRST_ARR, MD_FIRST_OBJ, MD_KEY, MD_COLON, MD_AFTER, MD_END,
      MD_STR, MD_ESC, MD_HEX,
      MD_LIT, MD_NSIGN, MD_NZERO, MD_NINT, MD_NDOT, MD_NFRAC, MD_NEXP, MD_NEXPS,
      MD_NEXPD
   } mode_type;

   mode_type              mode_ff, mode_in, m;
   logic                  stack_mem [STACK_DEPTH];
   logic                  top_ff, below_ff;
   logic [LW-1:0]         lvl_ff, lvl_in;
   logic [CountBits-1:0]  cnt_ff, cnt_in;
   logic [2:0]            hex_ff, hex_in;
   logic                  fail_ff, fail_in, key_ff, key_in;
   lit_sel_type           sel_ff, sel_in;
   logic [2:0]            pos_ff, pos_in;
   logic                  push_en, push_obj, pop_en;
   logic                  done, slot_ok, top, fin_ok;
   logic [7:0]            b;
   logic [LW-1:0]         lim;
   logic                  ovalid_ff, owf_ff;
   logic [CountBits-1:0]  ocnt_ff;

   assign q_pop = q_valid && (!ovalid_ff || out_ready);
   assign b     = q_data.data;
   assign lim   = (32'(max_depth) > 32'(STACK_DEPTH - 1))
                  ? LW'(STACK_DEPTH - 1) : LW'(max_depth);
   assign slot_ok = lvl_ff <= lim && cnt_ff < max_values;
   // The innermost open container kind is kept in a register, with the one
   // below it beside it, so the stack memory only sees registered reads.
   assign top   = top_ff;

   always_comb begin
      mode_in = mode_ff; lvl_in = lvl_ff; cnt_in = cnt_ff; hex_in = hex_ff;
      fail_in = fail_ff; key_in = key_ff; sel_in = sel_ff; pos_in = pos_ff;
      push_en = 1'b0; push_obj = 1'b0; pop_en = 1'b0; m = mode_ff;
      done = (mode_ff == MD_LIT) ? (pos_ff == lit_len(sel_ff))
             : (mode_ff == MD_NZERO || mode_ff == MD_NINT || mode_ff == MD_NFRAC
                || mode_ff == MD_NEXPD);
      fin_ok = 1'b1;
      if (!fail_ff) begin
         if (mode_ff >= MD_LIT && !q_data.term) begin
            fin_ok = 1'b0;
            unique case (mode_ff)
               MD_LIT: if (pos_ff < lit_len(sel_ff) && b == lit_char(sel_ff, pos_ff))
                          pos_in = pos_ff + 3'd1;
                       else fail_in = 1'b1;
               MD_NSIGN: if (b == "0") mode_in = MD_NZERO;
                         else if (q_data.digit19) mode_in = MD_NINT;
                         else fail_in = 1'b1;
               MD_NZERO, MD_NINT: begin
                  if (mode_ff == MD_NINT && q_data.digit) ;
                  else if (b == ".") mode_in = MD_NDOT;
                  else if (q_data.exp_e) mode_in = MD_NEXP;
                  else fail_in = 1'b1;
               end
               MD_NDOT: if (q_data.digit) mode_in = MD_NFRAC; else fail_in = 1'b1;
               MD_NFRAC: begin
                  if (q_data.digit) ;
                  else if (q_data.exp_e) mode_in = MD_NEXP;
                  else fail_in = 1'b1;
               end
               MD_NEXP: if (b == "+" || b == "-") mode_in = MD_NEXPS;
                        else if (q_data.digit) mode_in = MD_NEXPD;
                        else fail_in = 1'b1;
               default: if (q_data.digit) mode_in = MD_NEXPD; else fail_in = 1'b1;
            endcase
         end else if (mode_ff >= MD_LIT && !done) begin
            fin_ok = 1'b0;
            fail_in = 1'b1;
         end
         if (fin_ok) begin
            if (mode_ff >= MD_LIT) m = (lvl_ff != '0) ? MD_AFTER : MD_END;
            mode_in = m;
            if (!(m <= MD_END && q_data.ws)) begin
               unique case (m)
                  MD_VALUE, MD_FIRST_ARR, MD_FIRST_OBJ, MD_KEY: begin
                     if ((m == MD_FIRST_ARR && b == "]") || (m == MD_FIRST_OBJ && b == "}")) begin
                        lvl_in  = lvl_ff - LW'(1);
                        pop_en  = 1'b1;
                        mode_in = (lvl_ff != LW'(1)) ? MD_AFTER : MD_END;
                     end else if ((m == MD_FIRST_OBJ || m == MD_KEY) && b != "\"") begin
                        fail_in = 1'b1;
                     end else if (!slot_ok) begin
                        fail_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + CountBits'(1);
                        if (m == MD_FIRST_OBJ || m == MD_KEY) begin
                           key_in = 1'b1; mode_in = MD_STR;
                        end else if (b == "{" || b == "[") begin
                           if (lvl_ff >= LW'(STACK_DEPTH)) fail_in = 1'b1;
                           else begin
                              push_en = 1'b1; push_obj = b == "{";
                              lvl_in  = lvl_ff + LW'(1);
                              mode_in = (b == "{") ? MD_FIRST_OBJ : MD_FIRST_ARR;
                           end
                        end else if (b == "\"") begin
                           key_in = 1'b0; mode_in = MD_STR;
                        end else if (b == "-") mode_in = MD_NSIGN;
                        else if (b == "0") mode_in = MD_NZERO;
                        else if (q_data.digit19) mode_in = MD_NINT;
                        else if (b == "n" || b == "t" || b == "f") begin
                           sel_in = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
                           pos_in = 3'd1; mode_in = MD_LIT;
                        end else fail_in = 1'b1;
                     end
                  end
                  MD_COLON: if (b == ":") mode_in = MD_VALUE; else fail_in = 1'b1;
                  MD_AFTER: begin
                     if (lvl_ff == '0) fail_in = 1'b1;
                     else if (b == (top ? "}" : "]")) begin
                        lvl_in  = lvl_ff - LW'(1);
                        pop_en  = 1'b1;
                        mode_in = (lvl_ff != LW'(1)) ? MD_AFTER : MD_END;
                     end else if (b == ",") mode_in = top ? MD_KEY : MD_VALUE;
                     else fail_in = 1'b1;
                  end
                  MD_STR: begin
                     if (b == "\"") mode_in = key_ff ? MD_COLON
                                    : ((lvl_ff != '0) ? MD_AFTER : MD_END);
                     else if (q_data.ctrl) fail_in = 1'b1;
                     else if (b == "\\") mode_in = MD_ESC;
                  end
                  MD_ESC: begin
                     if (b == "u") begin hex_in = 3'd4; mode_in = MD_HEX; end
                     else if (q_data.esc_ok) mode_in = MD_STR;
                     else fail_in = 1'b1;
                  end
                  MD_HEX: begin
                     if (!q_data.hex || hex_ff == 3'd0) fail_in = 1'b1;
                     else begin
                        hex_in = hex_ff - 3'd1;
                        if (hex_ff == 3'd1) mode_in = MD_STR;
                     end
                  end
                  default: fail_in = 1'b1;
               endcase
            end
         end
      end
      // End of document: a finished scalar closes, an unfinished one fails.
      if (q_data.last && !fail_in && mode_in >= MD_LIT) begin
         if ((mode_in == MD_LIT) ? (pos_in == lit_len(sel_in))
             : (mode_in == MD_NZERO || mode_in == MD_NINT || mode_in == MD_NFRAC
                || mode_in == MD_NEXPD))
            mode_in = (lvl_in != '0) ? MD_AFTER : MD_END;
         else fail_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && push_en) stack_mem[IW'(lvl_ff)] <= push_obj;
   end

   // On a pop the entry two below the old top is fetched, so the pair of
   // registers again holds the two innermost containers.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= 1'b0;
         below_ff <= 1'b0;
      end else if (q_pop && push_en) begin
         top_ff   <= push_obj;
         below_ff <= top_ff;
      end else if (q_pop && pop_en) begin
         top_ff <= below_ff;
         if (lvl_ff >= LW'(3)) below_ff <= stack_mem[IW'(lvl_ff - LW'(3))];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.last) begin
         owf_ff  <= !fail_in && mode_in == MD_END;
         ocnt_ff <= (!fail_in && mode_in == MD_END) ? cnt_in : '0;
      end
      if (reset || (q_pop && q_data.last)) begin
         mode_ff <= MD_VALUE; lvl_ff <= '0; cnt_ff <= '0; hex_ff <= 3'd0;
         fail_ff <= 1'b0; key_ff <= 1'b0; sel_ff <= LIT_NULL; pos_ff <= 3'd0;
      end else if (q_pop) begin
         mode_ff <= mode_in; lvl_ff <= lvl_in; cnt_ff <= cnt_in; hex_ff <= hex_in;
         fail_ff <= fail_in; key_ff <= key_in; sel_ff <= sel_in; pos_ff <= pos_in;
      end
      if (reset) ovalid_ff <= 1'b0;
      else if (q_pop && q_data.last) ovalid_ff <= 1'b1;
      else if (out_ready) ovalid_ff <= 1'b0;
   end

   assign out_valid       = ovalid_ff;
   assign out_well_formed = owf_ff;
   assign out_count       = ocnt_ff;

endmodule

// ===== design/jsv_checker.sv =====
// ----------------------------------------------------------------------------
// JSV port checker
// Watches the top-level ports for result and configuration port behavior.
// ----------------------------------------------------------------------------
module jsv_checker
   import jsv_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_well_formed,
   input logic [CountBits-1:0] rsp_value_count,
   input logic                 csr_pready
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_count))
      else $error("result changed while stalled");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_well_formed |-> rsp_value_count == '0)
      else $error("failed document reports a count");
   a_good_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_well_formed |-> rsp_value_count != '0)
      else $error("valid document with no values");
   a_ready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind json_syntax_validator jsv_checker u_chk (
   .clock, .reset,
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_well_formed (rsp.well_formed), .rsp_value_count (rsp.value_count),
   .csr_pready
);
